// File: rtl/mdee_pkg.sv
// Package: shared constants, command codes and control structs for the modular division core.
`default_nettype none
package mdee_pkg;

  localparam int VALUE_WIDTH = 32;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP         = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD        = 4'd1;
  localparam logic [OP_W-1:0] OP_DIV_D_START = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV_STEP    = 4'd3;
  localparam logic [OP_W-1:0] OP_SET_D       = 4'd4;
  localparam logic [OP_W-1:0] OP_SET_Y       = 4'd5;
  localparam logic [OP_W-1:0] OP_DIV_R_START = 4'd6;
  localparam logic [OP_W-1:0] OP_MUL_T_START = 4'd7;
  localparam logic [OP_W-1:0] OP_MUL_STEP    = 4'd8;
  localparam logic [OP_W-1:0] OP_UPDATE      = 4'd9;
  localparam logic [OP_W-1:0] OP_MUL_Y_START = 4'd10;
  localparam logic [OP_W-1:0] OP_RES_OK      = 4'd11;
  localparam logic [OP_W-1:0] OP_RES_BAD     = 4'd12;

  typedef struct packed {
    logic [31:0] divisor_value;
    logic [31:0] dividend_value;
    logic [31:0] modulus_value;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] quotient_value;
    logic        coprime_flag;
  } out_beat_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic m_zero;
    logic r1_zero;
    logic r0_one;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/mdee_datapath.sv
// Datapath: operand registers, bit-serial divider, serial modular multiplier, Euclid update.
`default_nettype none
module mdee_datapath #(
  parameter int W = mdee_pkg::VALUE_WIDTH
) (
  input  wire logic              clk,
  input  wire mdee_pkg::cmd_t    cmd,
  input  wire logic [W-1:0]      ld_div,
  input  wire logic [W-1:0]      ld_dvd,
  input  wire logic [W-1:0]      ld_mod,
  output mdee_pkg::status_t      st,
  output logic [W-1:0]           res_q,
  output logic                   res_f
);

  logic [W-1:0] mr, dv, yv, y;
  logic [W-1:0] r0, r1, t0, t1;
  logic [W-1:0] n, rem, den;
  logic [W-1:0] ma, mb, acc;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  // divider step
  logic [W:0]   remw, remd;
  logic         ge;
  // multiplier step
  logic [W-1:0] dbl, acc_step;
  // quotient reduced by modulus, Euclid coefficient
  logic [W-1:0] qred, tn;

  always_comb begin
    remw     = {rem, n[W-1]};
    ge       = remw >= {1'b0, den};
    remd     = remw - {1'b0, den};
    dbl      = add_mod(acc, acc, mr);
    acc_step = mb[W-1] ? add_mod(dbl, ma, mr) : dbl;
    qred     = (n >= mr) ? n - mr : n;
    tn       = (t0 >= acc) ? t0 - acc : t0 + (mr - acc);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      mdee_pkg::OP_LOAD: begin
        dv <= ld_div;
        yv <= ld_dvd;
        mr <= ld_mod;
      end
      mdee_pkg::OP_DIV_D_START: begin
        n   <= dv;
        rem <= '0;
        den <= mr;
      end
      mdee_pkg::OP_DIV_STEP: begin
        n   <= {n[W-2:0], ge};
        rem <= ge ? remd[W-1:0] : remw[W-1:0];
      end
      mdee_pkg::OP_SET_D: begin
        r0  <= mr;
        r1  <= rem;
        t0  <= '0;
        t1  <= (mr == W'(1)) ? '0 : W'(1);
        n   <= yv;
        rem <= '0;
        den <= mr;
      end
      mdee_pkg::OP_SET_Y: begin
        y <= rem;
      end
      mdee_pkg::OP_DIV_R_START: begin
        n   <= r0;
        rem <= '0;
        den <= r1;
      end
      mdee_pkg::OP_MUL_T_START: begin
        ma  <= t1;
        mb  <= qred;
        acc <= '0;
      end
      mdee_pkg::OP_MUL_Y_START: begin
        ma  <= y;
        mb  <= t0;
        acc <= '0;
      end
      mdee_pkg::OP_MUL_STEP: begin
        acc <= acc_step;
        mb  <= {mb[W-2:0], 1'b0};
      end
      mdee_pkg::OP_UPDATE: begin
        r0 <= r1;
        r1 <= rem;
        t0 <= t1;
        t1 <= tn;
      end
      mdee_pkg::OP_RES_OK: begin
        res_q <= acc;
        res_f <= 1'b1;
      end
      mdee_pkg::OP_RES_BAD: begin
        res_q <= '0;
        res_f <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign st.m_zero  = (mr == '0);
  assign st.r1_zero = (r1 == '0);
  assign st.r0_one  = (r0 == W'(1));

endmodule
`default_nettype wire

// File: rtl/mdee_ctrl.sv
// Controller: sequences loads, serial divisions, serial multiplies and result hand-off.
`default_nettype none
module mdee_ctrl #(
  parameter int W = mdee_pkg::VALUE_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire mdee_pkg::status_t  st,
  output mdee_pkg::cmd_t          cmd
);

  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MCHK  = 4'd1;
  localparam logic [3:0] S_DIVD  = 4'd2;
  localparam logic [3:0] S_SETD  = 4'd3;
  localparam logic [3:0] S_DIVY  = 4'd4;
  localparam logic [3:0] S_SETY  = 4'd5;
  localparam logic [3:0] S_CHECK = 4'd6;
  localparam logic [3:0] S_DIVQ  = 4'd7;
  localparam logic [3:0] S_QRED  = 4'd8;
  localparam logic [3:0] S_MULT  = 4'd9;
  localparam logic [3:0] S_UPD   = 4'd10;
  localparam logic [3:0] S_FMUL  = 4'd11;
  localparam logic [3:0] S_OK    = 4'd12;
  localparam logic [3:0] S_BAD   = 4'd13;

  logic [3:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          out_valid_next;
  logic          out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd.op         = mdee_pkg::OP_NOP;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = mdee_pkg::OP_LOAD;
          state_next = S_MCHK;
        end
      end
      S_MCHK: begin
        if (st.m_zero) begin
          state_next = S_BAD;
        end else begin
          cmd.op     = mdee_pkg::OP_DIV_D_START;
          state_next = S_DIVD;
        end
      end
      S_DIVD, S_DIVY, S_DIVQ: begin
        cmd.op   = mdee_pkg::OP_DIV_STEP;
        cnt_next = cnt + CW'(1);
        if (cnt == LAST) begin
          cnt_next = '0;
          case (state)
            S_DIVD:  state_next = S_SETD;
            S_DIVY:  state_next = S_SETY;
            default: state_next = S_QRED;
          endcase
        end
      end
      S_SETD: begin
        cmd.op     = mdee_pkg::OP_SET_D;
        state_next = S_DIVY;
      end
      S_SETY: begin
        cmd.op     = mdee_pkg::OP_SET_Y;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!st.r1_zero) begin
          cmd.op     = mdee_pkg::OP_DIV_R_START;
          state_next = S_DIVQ;
        end else if (st.r0_one) begin
          cmd.op     = mdee_pkg::OP_MUL_Y_START;
          state_next = S_FMUL;
        end else begin
          state_next = S_BAD;
        end
      end
      S_QRED: begin
        cmd.op     = mdee_pkg::OP_MUL_T_START;
        state_next = S_MULT;
      end
      S_MULT, S_FMUL: begin
        cmd.op   = mdee_pkg::OP_MUL_STEP;
        cnt_next = cnt + CW'(1);
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = (state == S_MULT) ? S_UPD : S_OK;
        end
      end
      S_UPD: begin
        cmd.op     = mdee_pkg::OP_UPDATE;
        state_next = S_CHECK;
      end
      S_OK, S_BAD: begin
        if (out_free) begin
          cmd.op         = (state == S_OK) ? mdee_pkg::OP_RES_OK : mdee_pkg::OP_RES_BAD;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/modular_division_ext_euclid_core.sv
// Top level: modular division by extended Euclid (controller plus datapath).
//
//  channel | direction | handshake          | beat payload
//  --------+-----------+--------------------+----------------------------------------
//  in      | into core | in_valid/in_stall  | divisor, dividend, modulus (32 b each)
//  out     | from core | out_valid/out_stall| quotient (32 b), coprime flag
//
//  Each item is loaded, its divisor and dividend are reduced by the modulus, and then k Euclid
//  steps run (about 46 at most for W = 32); the bit-serial divider and the double-and-add
//  multiplier are the serial arithmetic units and are used in turn.
//  One item at a time; in_stall is high from acceptance until the result is registered.
//  A result waits in the output register under out_stall while the next beat is accepted.
//  rst is synchronous and clears the controller and out_valid only.
`default_nettype none
module modular_division_ext_euclid_core #(
  parameter int VALUE_WIDTH = mdee_pkg::VALUE_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mdee_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mdee_pkg::out_beat_t      out_data
);

  localparam int W  = VALUE_WIDTH;
  // common width for moving between the 32-bit fields and the working width
  localparam int EW = (W > 32) ? W : 32;

  mdee_pkg::cmd_t    cmd;
  mdee_pkg::status_t st;
  logic [W-1:0]      res_q;
  logic              res_f;
  logic [EW-1:0]     e_div, e_dvd, e_mod, e_res;

  // inputs truncated to / zero-extended to the working width
  assign e_div = EW'(in_data.divisor_value);
  assign e_dvd = EW'(in_data.dividend_value);
  assign e_mod = EW'(in_data.modulus_value);
  assign e_res = EW'(res_q);

  mdee_ctrl #(.W(W)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  mdee_datapath #(.W(W)) u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .ld_div (e_div[W-1:0]),
    .ld_dvd (e_dvd[W-1:0]),
    .ld_mod (e_mod[W-1:0]),
    .st     (st),
    .res_q  (res_q),
    .res_f  (res_f)
  );

  assign out_data.quotient_value = e_res[31:0];
  assign out_data.coprime_flag   = res_f;

`ifndef NO_ASSERTIONS
  // an accepted beat makes the core busy at once
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("core not busy after accepting a beat");

  // a non-coprime result always carries zero
  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.coprime_flag) |-> (out_data.quotient_value == 32'd0))
    else $error("non-coprime result is not zero");

  // a new result appears only as the core returns to idle
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result raised while core still busy");

  // load only ever happens on an accepted beat
  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == mdee_pkg::OP_LOAD) |-> (in_valid && !in_stall))
    else $error("operand load without an accepted beat");
`endif

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for the modular division core: scoreboard class, stimulus and checks.
`timescale 1ns / 1ps
`default_nettype none
module tb;

  // Scoreboard: predicts quotient and coprime flag per accepted beat, checks results in order.
  class quotient_board;
    mdee_pkg::out_beat_t pending_q[$];
    int                  fail_count;

    // (a * b) mod m by double and add, a and b already reduced
    static function logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [63:0] acc;
      acc = '0;
      for (int i = 63; i >= 0; i--) begin
        acc = (acc + acc) % m;
        if (b[i]) acc = (acc + a) % m;
      end
      return acc;
    endfunction

    function mdee_pkg::out_beat_t predict(mdee_pkg::in_beat_t b);
      mdee_pkg::out_beat_t r;
      logic [63:0]         m, d, y, r0, r1, t0, t1, q, rn, tn, prod;
      r = '0;
      m = 64'(b.modulus_value);
      if (m != 64'd0) begin
        d  = 64'(b.divisor_value) % m;
        y  = 64'(b.dividend_value) % m;
        r0 = m;
        r1 = d;
        t0 = 64'd0;
        t1 = (m == 64'd1) ? 64'd0 : 64'd1;
        for (int s = 0; s < 128 && r1 != 64'd0; s++) begin
          q    = r0 / r1;
          rn   = r0 - q * r1;
          prod = mulmod(q % m, t1, m);
          tn   = (t0 >= prod) ? t0 - prod : t0 + (m - prod);
          r0 = r1; r1 = rn; t0 = t1; t1 = tn;
        end
        if (r0 == 64'd1) begin
          r.coprime_flag   = 1'b1;
          r.quotient_value = 32'(mulmod(y, t0 % m, m));
        end
      end
      return r;
    endfunction

    function void note_beat(mdee_pkg::in_beat_t b);
      pending_q.insert(pending_q.size(), predict(b));
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      fail_count++;
    endtask

    task check_result(mdee_pkg::out_beat_t got);
      mdee_pkg::out_beat_t exp;
      if (pending_q.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      exp = pending_q.pop_front();
      if (got.quotient_value !== exp.quotient_value)
        report($sformatf("quotient %0h, want %0h", got.quotient_value, exp.quotient_value));
      if (got.coprime_flag !== exp.coprime_flag)
        report($sformatf("coprime %0b, want %0b", got.coprime_flag, exp.coprime_flag));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  mdee_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mdee_pkg::out_beat_t out_data;

  quotient_board board = new();
  int  send_idle_pct = 9;    // sender gap chance, percent
  int  recv_idle_pct = 62;   // receiver stall chance, percent
  int  hold_cycles   = 0;    // long receiver hold-off, counted down on its own
  bit  stim_done     = 1'b0;

  modular_division_ext_euclid_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Drive one beat from the falling edge; hold it until accepted at a rising edge.
  // Valid stays high into the next call, which drops it only for a sender gap.
  task send_beat(logic [31:0] dv, logic [31:0] yv, logic [31:0] mv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{divisor_value: dv, dividend_value: yv, modulus_value: mv};
    do @(posedge clk); while (in_stall);
    board.note_beat(in_data);
    @(negedge clk);
  endtask

  // Random beat: mostly valid operands below modulus, some over-range and odd moduli.
  task send_random;
    logic [31:0] mv, dv, yv;
    int          sel;
    sel = $urandom_range(9);
    case (sel)
      0:       mv = $urandom_range(16, 1);
      1:       mv = 32'hFFFF_FFFF - $urandom_range(8);
      2:       mv = $urandom_range(1000, 2) | 32'h1;
      default: mv = $urandom();
    endcase
    if (mv == 0) mv = 1;
    dv = $urandom();
    yv = $urandom();
    if ($urandom_range(9) != 0) begin
      dv = dv % mv;
      yv = yv % mv;
    end
    if ($urandom_range(19) == 0) dv = 0;
    if ($urandom_range(29) == 0) mv = 0;
    send_beat(dv, yv, mv);
  endtask

  // Receiver: random stall, plus a long hold-off when hold_cycles is loaded.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check every result beat at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_data);
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes and special cases.
    send_beat(32'd3, 32'd4, 32'd7);                       // ordinary inverse
    send_beat(32'd4, 32'd6, 32'd8);                       // not coprime
    send_beat(32'd5, 32'd9, 32'd1);                       // modulus of one
    send_beat(32'd5, 32'd9, 32'd0);                       // modulus of zero
    send_beat(32'd0, 32'd9, 32'd13);                      // divisor zero
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_beat(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFB);       // dividend over range
    send_beat(32'd100, 32'd200, 32'd17);                  // both over range
    send_beat(32'h8000_0000, 32'h5555_5555, 32'hFFFF_FFFB);
    send_beat(32'hB520_4BD1, 32'hAAAA_AAAA, 32'hDB71_0641); // large operands
    send_beat(32'd1, 32'd0, 32'd2);
    send_beat(32'd0, 32'd0, 32'd1);
    send_beat(32'd6, 32'd1, 32'd9);

    // Long receiver hold-off while the sender keeps offering beats.
    hold_cycles = 12000;
    repeat (4) send_random();

    for (int i = 0; i < 356; i++) begin
      if (i == 120) begin send_idle_pct = 62; recv_idle_pct = 9; end
      if (i == 240) begin send_idle_pct = 0;  recv_idle_pct = 0; end
      send_random();
    end
    in_valid  <= 1'b0;
    stim_done = 1'b1;
  end

  // End of run: drain expectations, allow latency, then give the verdict.
  initial begin
    wait (stim_done);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (board.fail_count == 0 && board.pending_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #60ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
rtl/mdee_pkg.sv
rtl/mdee_datapath.sv
rtl/mdee_ctrl.sv
rtl/modular_division_ext_euclid_core.sv
tb/sv/tb.sv
